/* hdl/wse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wse_pkg: shared types and constants of the windowed entropy block
// Holds register indexes, fixed field widths and the fixed-point log2 helper.
// ----------------------------------------------------------------------------
package wse_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int ENTROPY_W  = 19;
    localparam int GUARD_BITS = 6;
    localparam int MANT_FRAC  = 30;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 8'd1;

    // Control lines from the sequencer to every cell of the chain.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // log2(x) with frac fraction bits, truncated; mantissa squared in Q30.
    function automatic longint unsigned log2_fixed(int x, int frac);
        int              k;
        longint unsigned m;
        longint unsigned r;
        k = 0;
        r = 0;
        if (x <= 0) begin
            return 0;
        end
        for (int j = 0; j < 31; j++) begin
            if ((x >> (k + 1)) != 0) begin
                k = k + 1;
            end
        end
        m = longint'(x) << (MANT_FRAC - k);
        r = longint'(k) << frac;
        for (int i = 0; i < frac; i++) begin
            m = (m * m) >> MANT_FRAC;
            if (m >= (64'd2 << MANT_FRAC)) begin
                m = m >> 1;
                r = r | (64'd1 << (frac - 1 - i));
            end
        end
        return r;
    endfunction

endpackage

/* hdl/windowed_shannon_entropy.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_shannon_entropy: sliding-block Shannon entropy of integer keys
// Counts distinct keys per window in a chain of cells and emits the entropy.
// ----------------------------------------------------------------------------
// For a sample request that does not close a window, all cells compare the
// key at once and the matching cell counts up, or the first free cell takes
// the key. A sample that closes a window is taken and then holds o_stall
// high while the counts shift out of the chain one cell per cycle into the
// c*log2(c) multiplier. The flush state then drains the product pipeline. A
// one-bit-per-cycle restoring divider then forms the rounded mean over the
// dividend bits (33 at the default parameters) and reports completion. The
// output register then loads the result, and o_stall stays high until it
// loads, longer if the previous result is still waiting. The result then
// waits in the output register. Further samples are taken while it waits;
// once one of them closes the next window, o_stall stays high until the
// waiting result has been taken. Register writes are always ready and
// should be made only while the block is idle.
// ----------------------------------------------------------------------------
module windowed_shannon_entropy
    import wse_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int KEY_BITS     = 24,
    parameter int ENTROPY_FRAC = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [23:0]    i_sample_key,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ENTROPY_W-1:0]  o_entropy,
    output logic [15:0]           o_window_index,
    output logic                  o_row_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam int CW       = $clog2(WINDOW_MAX + 1);
    localparam int LOG_FRAC = ENTROPY_FRAC + GUARD_BITS;
    localparam int LOG_W    = $clog2($clog2(WINDOW_MAX) + 1) + LOG_FRAC;
    localparam int PW       = CW + LOG_W;
    localparam int DW       = PW + 1;
    localparam int VW       = CW + GUARD_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  r_state;
    logic [6:0]  r_ws;
    logic [15:0] r_rl;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_fill;
    logic [15:0] r_row;
    logic [15:0] r_wnum;
    logic [CW-1:0] r_n;
    logic [15:0] r_widx;
    logic        r_rlast;
    logic [CW-1:0] r_k;
    logic        r_flush;
    logic        r_out_valid;
    logic [ENTROPY_W-1:0] r_entropy;
    logic [15:0] r_out_widx;
    logic        r_out_rlast;

    logic        accept;
    logic [KEY_BITS-1:0] key;
    logic signed [31:0]  key_ext;
    t_cell_ctl   ctl;
    logic [WINDOW_MAX-1:0] match;
    logic [CW-1:0] count [WINDOW_MAX];
    logic        found;
    logic [CW-1:0] fill1;
    logic [16:0] row1;
    logic [15:0] ws_eff;
    logic [15:0] rl_eff;
    logic        row_end;
    logic        win_end;
    logic        op_valid;
    logic        op_total;
    logic [CW-1:0] op_value;
    logic [PW-1:0] acc_total;
    logic [PW-1:0] acc_sum;
    logic [PW-1:0] d;
    logic [DW-1:0] dividend;
    logic        div_start;
    logic        div_done;
    logic [DW-1:0] quot;

    assign o_stall        = (r_state != ST_IDLE);
    assign accept         = i_valid && !o_stall;
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_entropy      = r_entropy;
    assign o_window_index = r_out_widx;
    assign o_row_last     = r_out_rlast;

    // Keys compare in their low KEY_BITS bits after sign extension.
    assign key_ext = 32'(i_sample_key);
    assign key     = key_ext[KEY_BITS-1:0];

    assign ctl.load  = accept;
    assign ctl.shift = (r_state == ST_DRAIN) && (r_k != '0);

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic [CW-1:0] next_count;
        if (i == WINDOW_MAX - 1) begin : g_last
            assign next_count = '0;
        end else begin : g_mid
            assign next_count = count[i+1];
        end
        wse_cell #(
            .KEY_BITS (KEY_BITS),
            .CW       (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_key        (key),
            .i_ctl        (ctl),
            .i_occupied   (CW'(i) < r_used),
            .i_alloc      (!found && (r_used == CW'(i))),
            .i_next_count (next_count),
            .o_match      (match[i]),
            .o_count      (count[i])
        );
    end

    assign found = |match;

    // Window and row limits; zero acts as one, the window is capped at the chain length.
    always_comb begin
        ws_eff = 16'(r_ws);
        if (ws_eff == 16'd0) begin
            ws_eff = 16'd1;
        end else if (ws_eff > 16'(WINDOW_MAX)) begin
            ws_eff = 16'(WINDOW_MAX);
        end
        rl_eff  = (r_rl == 16'd0) ? 16'd1 : r_rl;
        fill1   = r_fill + CW'(1);
        row1    = {1'b0, r_row} + 17'd1;
        row_end = row1 >= {1'b0, rl_eff};
        win_end = row_end || (16'(fill1) >= ws_eff);
    end

    // During the drain, the first operand is the window length itself.
    assign op_valid = (r_state == ST_DRAIN);
    assign op_total = (r_k == '0);
    assign op_value = (r_k == '0) ? r_n : count[0];

    wse_accum #(
        .CW       (CW),
        .LOG_FRAC (LOG_FRAC),
        .LOG_W    (LOG_W)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (accept && win_end),
        .i_op_valid (op_valid),
        .i_op_total (op_total),
        .i_op_value (op_value),
        .o_total    (acc_total),
        .o_sum      (acc_sum)
    );

    // Entropy = (n*log2 n - sum c*log2 c) / (n * 2^guard), rounded half up.
    assign d         = (acc_total > acc_sum) ? acc_total - acc_sum : '0;
    assign dividend  = {1'b0, d} + (DW'(r_n) << (GUARD_BITS - 1));
    assign div_start = (r_state == ST_FLUSH) && r_flush;

    wse_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (VW'(r_n) << GUARD_BITS),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= 7'd8;
            r_rl        <= 16'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WINDOW_SIZE: r_ws <= i_cfg_data[6:0];
                REG_ROW_LENGTH:  r_rl <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_row       <= '0;
            r_wnum      <= '0;
            r_k         <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result loads as the old one leaves or once the register is empty.
            if ((r_state == ST_OUT) && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (!found && (16'(r_used) < 16'(WINDOW_MAX))) begin
                            r_used <= r_used + CW'(1);
                        end
                        if (win_end) begin
                            r_fill  <= '0;
                            r_n     <= fill1;
                            r_widx  <= r_wnum;
                            r_rlast <= row_end;
                            r_k     <= '0;
                            r_state <= ST_DRAIN;
                            if (row_end) begin
                                r_row  <= '0;
                                r_wnum <= '0;
                            end else begin
                                r_row  <= row1[15:0];
                                r_wnum <= r_wnum + 16'd1;
                            end
                        end else begin
                            r_fill <= fill1;
                            r_row  <= row1[15:0];
                        end
                    end
                end
                ST_DRAIN: begin
                    r_k <= r_k + CW'(1);
                    if (r_k == r_used) begin
                        r_used  <= '0;
                        r_flush <= 1'b0;
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_flush <= 1'b1;
                    if (r_flush) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && (!r_out_valid || !i_stall)) begin
            r_entropy   <= ENTROPY_W'(quot);
            r_out_widx  <= r_widx;
            r_out_rlast <= r_rlast;
        end
    end

endmodule

/* hdl/wse_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wse_cell: one key/count cell of the chain
// Compares the incoming key, counts hits, and shifts its count toward cell 0.
// ----------------------------------------------------------------------------
module wse_cell
    import wse_pkg::*;
#(
    parameter int KEY_BITS = 24,
    parameter int CW       = 7
) (
    input  logic                i_clk,
    input  logic [KEY_BITS-1:0] i_key,
    input  t_cell_ctl           i_ctl,
    input  logic                i_occupied,
    input  logic                i_alloc,
    input  logic [CW-1:0]       i_next_count,
    output logic                o_match,
    output logic [CW-1:0]       o_count
);

    logic [KEY_BITS-1:0] r_key;
    logic [CW-1:0]       r_count;

    assign o_match = i_occupied && (r_key == i_key);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_alloc) begin
            r_key   <= i_key;
            r_count <= CW'(1);
        end else if (i_ctl.load && o_match) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.shift) begin
            r_count <= i_next_count;
        end
    end

endmodule

/* hdl/wse_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wse_accum: c*log2(c) product and accumulator
// Looks up log2 in a constant table, multiplies, sums the count terms and keeps the total term apart.
// ----------------------------------------------------------------------------
module wse_accum
    import wse_pkg::*;
#(
    parameter int CW       = 7,
    parameter int LOG_FRAC = 22,
    parameter int LOG_W    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_op_valid,
    input  logic               i_op_total,
    input  logic [CW-1:0]      i_op_value,
    output logic [CW+LOG_W-1:0] o_total,
    output logic [CW+LOG_W-1:0] o_sum
);

    localparam int PW = CW + LOG_W;

    logic [LOG_W-1:0] lut [2**CW];
    logic [PW-1:0]    r_prod;
    logic             r_pv;
    logic             r_pt;
    logic [PW-1:0]    r_total;
    logic [PW-1:0]    r_sum;

    for (genvar g = 0; g < 2**CW; g++) begin : g_lut
        assign lut[g] = LOG_W'(log2_fixed(g, LOG_FRAC));
    end

    assign o_total = r_total;
    assign o_sum   = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_op_value) * PW'(lut[i_op_value]);
        r_pt   <= i_op_total;
        if (i_clear) begin
            r_sum <= '0;
        end else if (r_pv && !r_pt) begin
            r_sum <= r_sum + r_prod;
        end
        if (r_pv && r_pt) begin
            r_total <= r_prod;
        end
    end

endmodule

/* hdl/wse_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wse_div: restoring divider
// Produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wse_div #(
    parameter int DW = 33,
    parameter int VW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int NW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   rem_sh;
    logic          take;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign take   = rem_sh >= {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + NW'(1);
                if (r_cnt == NW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? VW'(rem_sh - {1'b0, r_div}) : VW'(rem_sh);
            r_quo <= {r_quo[DW-2:0], take};
        end
    end

endmodule
